@@ hw/rtl/irqc_pkg.sv @@
`default_nettype none

package irqc_pkg;

    // In-service stack depth; the counter holds 0..STACK_DEPTH
    localparam int STACK_DEPTH = 4;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int STACK_IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam int NUM_SRC = 6;

    // Item kinds
    localparam logic [1:0] KIND_RAISE  = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_SCAN   = 2'd2;
    localparam logic [1:0] KIND_RETURN = 2'd3;

    // Sources (same as vectors)
    localparam logic [2:0] SRC_EXT0   = 3'd0;
    localparam logic [2:0] SRC_TIMER0 = 3'd1;
    localparam logic [2:0] SRC_EXT1   = 3'd2;
    localparam logic [2:0] SRC_TIMER1 = 3'd3;
    localparam logic [2:0] SRC_SERIAL = 3'd4;
    localparam logic [2:0] SRC_TIMER2 = 3'd5;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_BLOCK_ENABLE   = 3'd0;
    localparam logic [2:0] REG_ENABLE_BITS    = 3'd1;
    localparam logic [2:0] REG_PRIORITY_BITS  = 3'd2;
    localparam logic [2:0] REG_EDGE_MODE      = 3'd3;
    localparam logic [2:0] REG_REACHABLE_MASK = 3'd4;
    localparam logic [2:0] REG_POWER_MODE     = 3'd5;

    localparam int          MASTER_EN_BIT  = 7;
    localparam logic [5:0]  REACHABLE_RESET = 6'h3F;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] source;
        logic [1:0] serial_flags;
        logic       timer2_flag;
    } cmd_t;

    typedef struct packed {
        logic       dispatched;
        logic [2:0] vector;
        logic       taken_priority;
        logic       wake;
        logic [5:0] pending_out;
        logic [3:0] hw_flags_out;
        logic [2:0] service_depth;
    } rsp_t;

    typedef struct packed {
        logic       block_enable;
        logic [7:0] enable_bits;
        logic [5:0] priority_bits;
        logic [1:0] edge_mode;
        logic [5:0] reachable_mask;
        logic [1:0] power_mode;
    } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/two_level_interrupt_controller.sv @@
//  Channel | Direction | Handshake              | Beat
//  --------+-----------+------------------------+-------------------------------
//  cmd     | in        | cmd_valid / cmd_stall  | cmd_t: kind, source, flags
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_t: one result per cmd beat
//  apb     | in        | psel/penable/pready    | config registers at 4*index
//
//  One cmd beat per cycle sustained while rsp_stall is low. The path is the input register,
//  then the select/update logic into the result register.
//  Reset clears pending, flags, stack, depth, suppress and the valid bits; config
//  goes to zero except reachable_mask (all six vectors); payloads are not reset.
//  A stalled result holds; the input register still takes a beat whenever
//  the result register is free or draining in the same cycle.
`default_nettype none

module two_level_interrupt_controller
    import irqc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cmd_valid,
    output logic             cmd_stall,
    input  wire cmd_t        cmd,

    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output rsp_t             rsp,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    cfg_t cfg;
    cmd_t s1_cmd_reg;
    logic s1_valid_reg;
    rsp_t rsp_reg;
    logic rsp_valid_reg;
    rsp_t core_rsp;

    logic out_free;    // result register can load this cycle
    logic advance;     // input register beat moves to result register
    logic cmd_take;

    irqc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // State updates in the core commit on the same edge the result is loaded,
    // so the next beat in the input register always sees fresh state.
    irqc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .cmd   (s1_cmd_reg),
        .cfg   (cfg),
        .rsp   (core_rsp)
    );

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign advance   = s1_valid_reg && out_free;
    assign cmd_stall = s1_valid_reg && !out_free;
    assign cmd_take  = cmd_valid && !cmd_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd_take)
            s1_cmd_reg <= cmd;
        if (advance)
            rsp_reg <= core_rsp;
    end

    // Stack depth reported never goes past the stack size
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (int'(rsp.service_depth) <= STACK_DEPTH))
        else $error("service depth above stack size");

    // A dispatch names one of the six sources and leaves its pending bit clear
    a_vec_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.dispatched) |-> (rsp.vector < 3'd6))
        else $error("dispatched vector out of range");

    a_taken_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.dispatched && rsp.vector < 3'd6) |->
            !rsp.pending_out[rsp.vector])
        else $error("dispatched source still pending");

    // The input side only stalls while a beat is held in the input register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (s1_valid_reg && rsp_valid_reg && rsp_stall))
        else $error("input stalled without a held beat");

endmodule

`default_nettype wire

@@ hw/rtl/irqc_cfg.sv @@
`default_nettype none

module irqc_cfg
    import irqc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_enable   <= 1'b0;
            cfg_reg.enable_bits    <= '0;
            cfg_reg.priority_bits  <= '0;
            cfg_reg.edge_mode      <= '0;
            cfg_reg.reachable_mask <= REACHABLE_RESET;
            cfg_reg.power_mode     <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_BLOCK_ENABLE:   cfg_reg.block_enable   <= pwdata[0];
                REG_ENABLE_BITS:    cfg_reg.enable_bits    <= pwdata[7:0];
                REG_PRIORITY_BITS:  cfg_reg.priority_bits  <= pwdata[5:0];
                REG_EDGE_MODE:      cfg_reg.edge_mode      <= pwdata[1:0];
                REG_REACHABLE_MASK: cfg_reg.reachable_mask <= pwdata[5:0];
                REG_POWER_MODE:     cfg_reg.power_mode     <= pwdata[1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            REG_BLOCK_ENABLE:   prdata = {31'd0, cfg_reg.block_enable};
            REG_ENABLE_BITS:    prdata = {24'd0, cfg_reg.enable_bits};
            REG_PRIORITY_BITS:  prdata = {26'd0, cfg_reg.priority_bits};
            REG_EDGE_MODE:      prdata = {30'd0, cfg_reg.edge_mode};
            REG_REACHABLE_MASK: prdata = {26'd0, cfg_reg.reachable_mask};
            REG_POWER_MODE:     prdata = {30'd0, cfg_reg.power_mode};
            default:            prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/irqc_core.sv @@
`default_nettype none

module irqc_core
    import irqc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic fire,
    input  wire cmd_t cmd,
    input  wire cfg_t cfg,
    output rsp_t      rsp
);

    logic [5:0]         pending_reg,  pending_next;
    logic [3:0]         hw_flags_reg, hw_flags_next;
    logic [DEPTH_W-1:0] depth_reg,    depth_next;
    logic               suppress_reg, suppress_next;
    logic [STACK_DEPTH-1:0] stack_reg, stack_next;

    logic [5:0]             flag_ok;
    logic [5:0]             cand;
    logic [5:0]             cand_hi;
    logic [5:0]             drop;
    logic                   has_cur;
    logic                   cur_p;
    logic [STACK_IDX_W-1:0] top_idx;
    logic [STACK_IDX_W-1:0] push_idx;
    logic [2:0]             best;
    logic                   best_p;
    logic [2:0]             src3;
    logic                   src_ok;
    logic                   master;

    // Lowest set bit of a six-bit mask
    function automatic logic [2:0] lowest_set(input logic [5:0] m);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = NUM_SRC - 1; i >= 0; i--)
        begin
            if (m[i])
                idx = 3'(i);
        end
        return idx;
    endfunction

    assign src3     = cmd.source[2:0];
    assign src_ok   = (cmd.source < 4'd6);
    assign master   = cfg.enable_bits[MASTER_EN_BIT];
    assign has_cur  = (depth_reg != '0);
    assign top_idx  = STACK_IDX_W'(depth_reg - DEPTH_W'(1));
    assign push_idx = STACK_IDX_W'(depth_reg);
    assign cur_p    = stack_reg[top_idx];

    // Per-source flag check; externals count as set in level mode
    assign flag_ok[0] = !cfg.edge_mode[0] || hw_flags_reg[0];
    assign flag_ok[1] = hw_flags_reg[1];
    assign flag_ok[2] = !cfg.edge_mode[1] || hw_flags_reg[2];
    assign flag_ok[3] = hw_flags_reg[3];
    assign flag_ok[4] = |cmd.serial_flags;
    assign flag_ok[5] = cmd.timer2_flag;

    always_comb
    begin
        for (int s = 0; s < NUM_SRC; s++)
        begin
            drop[s] = pending_reg[s] && (!cfg.reachable_mask[s] ||
                      (cfg.enable_bits[s] && !flag_ok[s]));
            cand[s] = pending_reg[s] && cfg.reachable_mask[s] && cfg.enable_bits[s] &&
                      flag_ok[s] && (!has_cur || (cfg.priority_bits[s] && !cur_p));
        end
        cand_hi = cand & cfg.priority_bits;
        best    = (cand_hi != '0) ? lowest_set(cand_hi) : lowest_set(cand);
        best_p  = (cand_hi != '0);
    end

    always_comb
    begin
        pending_next  = pending_reg;
        hw_flags_next = hw_flags_reg;
        depth_next    = depth_reg;
        suppress_next = suppress_reg;
        stack_next    = stack_reg;
        rsp           = '0;

        case (cmd.kind)
            KIND_RAISE:
            begin
                if (src_ok && cfg.reachable_mask[src3])
                begin
                    case (src3)
                        SRC_TIMER0: hw_flags_next[1] = 1'b1;
                        SRC_TIMER1: hw_flags_next[3] = 1'b1;
                        SRC_EXT0:   hw_flags_next[0] = hw_flags_reg[0] | cfg.edge_mode[0];
                        SRC_EXT1:   hw_flags_next[2] = hw_flags_reg[2] | cfg.edge_mode[1];
                        default:    ;
                    endcase
                    pending_next[src3] = 1'b1;
                    rsp.wake = cfg.power_mode[0] ||
                               (cfg.power_mode[1] && master &&
                                (src3 == SRC_EXT0 || src3 == SRC_EXT1));
                end
            end
            KIND_CLEAR:
            begin
                if (src_ok)
                    pending_next[src3] = 1'b0;
            end
            KIND_SCAN:
            begin
                if (!cfg.block_enable)
                begin
                end
                else if (suppress_reg)
                    suppress_next = 1'b0;
                else if (master && (pending_reg != '0))
                begin
                    pending_next = pending_reg & ~drop;
                    if (cand != '0)
                    begin
                        pending_next[best] = 1'b0;
                        if (best < 3'd4)
                            hw_flags_next[best[1:0]] = 1'b0;
                        if (depth_reg < DEPTH_W'(STACK_DEPTH))
                        begin
                            stack_next[push_idx] = best_p;
                            depth_next           = depth_reg + DEPTH_W'(1);
                        end
                        rsp.dispatched     = 1'b1;
                        rsp.vector         = best;
                        rsp.taken_priority = best_p;
                    end
                end
            end
            KIND_RETURN:
            begin
                if (has_cur)
                    depth_next = depth_reg - DEPTH_W'(1);
                suppress_next = 1'b1;
            end
            default: ;
        endcase

        rsp.pending_out   = pending_next;
        rsp.hw_flags_out  = hw_flags_next;
        rsp.service_depth = (int'(depth_next) > 7) ? 3'd7 : 3'(depth_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            hw_flags_reg <= '0;
            depth_reg    <= '0;
            suppress_reg <= 1'b0;
            stack_reg    <= '0;
        end
        else if (fire)
        begin
            pending_reg  <= pending_next;
            hw_flags_reg <= hw_flags_next;
            depth_reg    <= depth_next;
            suppress_reg <= suppress_next;
            stack_reg    <= stack_next;
        end
    end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import irqc_pkg::*;

    // Run shape
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 112;
    localparam int HOLD_PHASE  = 4;      // phase where the receiver holds off for a long stretch
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 20000;  // cycles to wait for outstanding results per phase
    localparam int TAIL_CYCLES = 6;      // margin after the last drain for stray beats

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    cmd_t        cmd_beat = '0;

    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp_beat;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    two_level_interrupt_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd_beat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp_beat),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Commands waiting to be driven, and the results they are predicted to give
    cmd_t cmd_backlog[$];
    rsp_t outcomes_due[$];

    // Idle/stall pattern, set per phase by the stimulus process (at negedge)
    int send_idle_pct = 0;
    int stall_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;

    // Shadow of the register file and of the controller state
    cfg_t reg_shadow;
    logic [5:0] irq_pending = '0;
    logic [3:0] irq_flags = '0;
    bit         level_stack [STACK_DEPTH];
    int         service_lvls = 0;
    bit         return_block = 1'b0;   // one-shot: next enabled scan after a return is skipped

    int err_count = 0;
    int n_items = 0;
    int n_settings = 0;
    int n_dispatch = 0;
    int n_wake = 0;

    // Advances the shadow state by one command and returns the result it gives.
    function automatic rsp_t dispatch_outcome(cmd_t c);
        rsp_t r;
        int   cur;
        int   best;
        int   bestp;
        int   p;
        bit   ok;
        r = '0;
        case (c.kind)
            KIND_RAISE: begin
                // unmapped or unreachable sources are ignored entirely
                if (c.source < NUM_SRC && reg_shadow.reachable_mask[c.source[2:0]]) begin
                    case (c.source[2:0])
                        SRC_TIMER0, SRC_TIMER1: irq_flags[c.source[1:0]] = 1'b1;
                        SRC_EXT0: if (reg_shadow.edge_mode[0]) irq_flags[SRC_EXT0] = 1'b1;
                        SRC_EXT1: if (reg_shadow.edge_mode[1]) irq_flags[SRC_EXT1] = 1'b1;
                        default: begin end
                    endcase
                    irq_pending[c.source[2:0]] = 1'b1;
                    if (reg_shadow.power_mode[0])
                        r.wake = 1'b1;
                    else if (reg_shadow.power_mode[1] && reg_shadow.enable_bits[MASTER_EN_BIT]
                             && (c.source[2:0] == SRC_EXT0 || c.source[2:0] == SRC_EXT1))
                        r.wake = 1'b1;
                end
            end
            KIND_CLEAR: begin
                if (c.source < NUM_SRC)
                    irq_pending[c.source[2:0]] = 1'b0;
            end
            KIND_SCAN: begin
                if (reg_shadow.block_enable && return_block) begin
                    return_block = 1'b0;
                end else if (reg_shadow.block_enable && reg_shadow.enable_bits[MASTER_EN_BIT]
                             && irq_pending != 0) begin
                    cur = -1;
                    best = -1;
                    bestp = -1;
                    if (service_lvls > 0)
                        cur = int'(level_stack[service_lvls - 1]);
                    for (int s = 0; s < NUM_SRC; s++) begin
                        if (!irq_pending[s])
                            continue;
                        if (!reg_shadow.reachable_mask[s]) begin
                            irq_pending[s] = 1'b0;
                            continue;
                        end
                        if (!reg_shadow.enable_bits[s])
                            continue;
                        case (s)
                            SRC_EXT0:   ok = !reg_shadow.edge_mode[0] || irq_flags[SRC_EXT0];
                            SRC_TIMER0: ok = irq_flags[SRC_TIMER0];
                            SRC_EXT1:   ok = !reg_shadow.edge_mode[1] || irq_flags[SRC_EXT1];
                            SRC_TIMER1: ok = irq_flags[SRC_TIMER1];
                            SRC_SERIAL: ok = (c.serial_flags != 0);
                            default:    ok = c.timer2_flag;
                        endcase
                        if (!ok) begin
                            irq_pending[s] = 1'b0;
                            continue;
                        end
                        p = int'(reg_shadow.priority_bits[s]);
                        if (p <= cur)
                            continue;
                        if (best < 0 || p > bestp) begin
                            best = s;
                            bestp = p;
                        end
                    end
                    if (best >= 0) begin
                        irq_pending[best] = 1'b0;
                        // only the four hardware-flagged sources auto-clear
                        if (best < int'(SRC_SERIAL))
                            irq_flags[best] = 1'b0;
                        if (service_lvls < STACK_DEPTH) begin
                            level_stack[service_lvls] = bestp[0];
                            service_lvls++;
                        end
                        r.dispatched = 1'b1;
                        r.vector = best[2:0];
                        r.taken_priority = bestp[0];
                    end
                end
            end
            default: begin
                // return from interrupt: pop if anything is in service, block the next scan
                if (service_lvls > 0)
                    service_lvls--;
                return_block = 1'b1;
            end
        endcase
        r.pending_out = irq_pending;
        r.hw_flags_out = irq_flags;
        r.service_depth = service_lvls[2:0];
        if (r.dispatched) n_dispatch++;
        if (r.wake) n_wake++;
        return r;
    endfunction

    // Driver: predicts on every accepted beat, then offers the next one
    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_valid <= 1'b0;
        end else begin
            if (cmd_valid && !cmd_stall)
                outcomes_due.push_back(dispatch_outcome(cmd_beat));
            // a stalled beat holds; otherwise pick the next one or idle
            if (!cmd_valid || !cmd_stall) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cmd_valid <= 1'b1;
                    cmd_beat <= cmd_backlog.pop_front();
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [7:0] exp, logic [7:0] act);
        if (act !== exp) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
            err_count++;
        end
    endtask

    // Monitor: checks each accepted result beat against the oldest prediction,
    // and drives the stall pattern (random, or a long hold-off on request)
    always @(posedge clk) begin
        rsp_t exp;
        if (!rst_n) begin
            rsp_stall <= 1'b0;
        end else begin
            if (rsp_valid && !rsp_stall) begin
                if (outcomes_due.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, rsp_beat);
                    err_count++;
                end else begin
                    exp = outcomes_due.pop_front();
                    check_field("dispatched", exp.dispatched, rsp_beat.dispatched);
                    check_field("vector", exp.vector, rsp_beat.vector);
                    check_field("taken_priority", exp.taken_priority, rsp_beat.taken_priority);
                    check_field("wake", exp.wake, rsp_beat.wake);
                    check_field("pending_out", exp.pending_out, rsp_beat.pending_out);
                    check_field("hw_flags_out", exp.hw_flags_out, rsp_beat.hw_flags_out);
                    check_field("service_depth", exp.service_depth, rsp_beat.service_depth);
                end
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_stall <= 1'b1;
            end else begin
                rsp_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // APB write: setup then access; lands on the edge with psel/penable/pwrite high
    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BLOCK_ENABLE:   reg_shadow.block_enable = value[0];
            REG_ENABLE_BITS:    reg_shadow.enable_bits = value[7:0];
            REG_PRIORITY_BITS:  reg_shadow.priority_bits = value[5:0];
            REG_EDGE_MODE:      reg_shadow.edge_mode = value[1:0];
            REG_REACHABLE_MASK: reg_shadow.reachable_mask = value[5:0];
            default:            reg_shadow.power_mode = value[1:0];
        endcase
        @(negedge clk);
    endtask

    task automatic apply_config(cfg_t c);
        apb_write(REG_BLOCK_ENABLE, 32'(c.block_enable));
        apb_write(REG_ENABLE_BITS, 32'(c.enable_bits));
        apb_write(REG_PRIORITY_BITS, 32'(c.priority_bits));
        apb_write(REG_EDGE_MODE, 32'(c.edge_mode));
        apb_write(REG_REACHABLE_MASK, 32'(c.reachable_mask));
        apb_write(REG_POWER_MODE, 32'(c.power_mode));
        n_settings++;
    endtask

    task automatic push_cmd(logic [1:0] kind, logic [3:0] source, logic [1:0] ser, logic t2);
        cmd_t c;
        c.kind = kind;
        c.source = source;
        c.serial_flags = ser;
        c.timer2_flag = t2;
        cmd_backlog.push_back(c);
        n_items++;
    endtask

    // Mostly raise bursts (sometimes with a clear) followed by a scan (and often a return), plus raw noise
    task automatic fill_random(int count);
        int left;
        int n_raise;
        left = count;
        while (left > 0) begin
            if ($urandom_range(99) < 75) begin
                n_raise = $urandom_range(3, 1);
                for (int j = 0; j < n_raise; j++)
                    push_cmd(KIND_RAISE, 4'($urandom_range(5)), 2'($urandom_range(3)),
                             1'($urandom_range(1)));
                if ($urandom_range(99) < 20) begin
                    push_cmd(KIND_CLEAR, 4'($urandom_range(5)), 2'($urandom_range(3)),
                             1'($urandom_range(1)));
                    left--;
                end
                push_cmd(KIND_SCAN, 4'($urandom_range(15)), 2'($urandom_range(3)),
                         1'($urandom_range(1)));
                left -= n_raise + 1;
                if ($urandom_range(99) < 60) begin
                    push_cmd(KIND_RETURN, 4'($urandom_range(15)), 2'($urandom_range(3)),
                             1'($urandom_range(1)));
                    left--;
                end
            end else begin
                push_cmd(2'($urandom_range(3)), 4'($urandom_range(15)), 2'($urandom_range(3)),
                         1'($urandom_range(1)));
                left--;
            end
        end
    endtask

    // Sender pause: nothing left to send and every prediction matched by a beat
    task automatic wait_drained();
        int spin;
        spin = 0;
        while ((cmd_backlog.size() != 0 || cmd_valid || outcomes_due.size() != 0)
               && spin < DRAIN_LIMIT) begin
            @(negedge clk);
            spin++;
        end
        if (outcomes_due.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, outcomes_due.size());
            err_count++;
        end
    endtask

    initial begin
        cfg_t cfg;
        reg_shadow = '0;
        reg_shadow.reachable_mask = REACHABLE_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: ext1 and serial at high level, edge mode on both externals, idle mode
        cfg = '0;
        cfg.block_enable = 1'b1;
        cfg.enable_bits = 8'hBF;
        cfg.priority_bits = 6'b010100;
        cfg.edge_mode = 2'b11;
        cfg.reachable_mask = 6'h3F;
        cfg.power_mode = 2'b01;
        apply_config(cfg);
        push_cmd(KIND_RAISE, 4'(SRC_EXT0), 2'd0, 1'b0);
        push_cmd(KIND_RAISE, 4'(SRC_TIMER0), 2'd0, 1'b0);
        push_cmd(KIND_RAISE, 4'(SRC_EXT1), 2'd0, 1'b0);
        push_cmd(KIND_RAISE, 4'(SRC_TIMER1), 2'd0, 1'b0);
        push_cmd(KIND_RAISE, 4'(SRC_SERIAL), 2'd0, 1'b0);
        push_cmd(KIND_RAISE, 4'(SRC_TIMER2), 2'd0, 1'b0);
        push_cmd(KIND_RAISE, 4'd15, 2'd3, 1'b1);                // unmapped source
        push_cmd(KIND_CLEAR, 4'd9, 2'd0, 1'b0);                 // unmapped clear
        push_cmd(KIND_SCAN, 4'd0, 2'd0, 1'b0);                  // ext1 high; serial/timer2 dropped
        push_cmd(KIND_SCAN, 4'd0, 2'd0, 1'b0);                  // nothing above high level
        push_cmd(KIND_RETURN, 4'd0, 2'd0, 1'b0);
        push_cmd(KIND_SCAN, 4'd0, 2'd0, 1'b0);                  // swallowed by the one-shot
        push_cmd(KIND_SCAN, 4'd0, 2'd0, 1'b0);                  // low-level tie, lowest vector
        push_cmd(KIND_RAISE, 4'(SRC_SERIAL), 2'd0, 1'b0);
        push_cmd(KIND_SCAN, 4'd15, 2'd2, 1'b0);                 // serial preempts low level
        push_cmd(KIND_RETURN, 4'd0, 2'd0, 1'b0);
        push_cmd(KIND_RETURN, 4'd0, 2'd0, 1'b0);
        push_cmd(KIND_RETURN, 4'd0, 2'd0, 1'b0);                // empty stack
        push_cmd(KIND_CLEAR, 4'(SRC_TIMER0), 2'd0, 1'b0);
        wait_drained();

        // Directed: power down, block disabled, partial reachability, level mode
        cfg = '0;
        cfg.enable_bits = 8'h80;
        cfg.reachable_mask = 6'h2D;
        cfg.power_mode = 2'b10;
        apply_config(cfg);
        push_cmd(KIND_RAISE, 4'(SRC_EXT0), 2'd0, 1'b0);         // wakes from power down
        push_cmd(KIND_RAISE, 4'(SRC_TIMER0), 2'd0, 1'b0);       // unreachable
        push_cmd(KIND_RAISE, 4'(SRC_TIMER1), 2'd0, 1'b0);       // no wake for a timer
        push_cmd(KIND_SCAN, 4'd0, 2'd3, 1'b1);                  // block disabled
        push_cmd(KIND_RETURN, 4'd0, 2'd0, 1'b0);
        push_cmd(KIND_SCAN, 4'd0, 2'd3, 1'b1);                  // disabled: one-shot kept
        wait_drained();

        cfg.block_enable = 1'b1;
        cfg.enable_bits = 8'h3F;                                // master enable off
        apply_config(cfg);
        push_cmd(KIND_SCAN, 4'd0, 2'd3, 1'b1);                  // clears the one-shot
        push_cmd(KIND_SCAN, 4'd0, 2'd3, 1'b1);                  // master off
        wait_drained();

        for (int k = 0; k < RAND_PHASES; k++) begin
            case (k % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 63; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 63; end
                default: begin send_idle_pct = 20; stall_pct = 20; end
            endcase
            if (k == 0) begin
                cfg.block_enable = 1'b1;
                cfg.enable_bits = 8'hFF;
                cfg.priority_bits = 6'h3F;
                cfg.edge_mode = 2'h3;
                cfg.reachable_mask = 6'h3F;
                cfg.power_mode = 2'h3;
            end else if (k == 1) begin
                cfg = '0;
            end else begin
                // mostly dispatch-capable settings, with some fully random ones
                cfg.block_enable = ($urandom_range(99) < 85);
                cfg.enable_bits = 8'($urandom_range(255));
                cfg.enable_bits[MASTER_EN_BIT] = ($urandom_range(99) < 85);
                cfg.priority_bits = 6'($urandom_range(63));
                cfg.edge_mode = 2'($urandom_range(3));
                cfg.reachable_mask = ($urandom_range(99) < 70) ? 6'h3F : 6'($urandom_range(63));
                cfg.power_mode = 2'($urandom_range(3));
            end
            apply_config(cfg);
            fill_random(PHASE_ITEMS);
            // long receiver hold-off while the sender keeps offering: backs up into cmd_stall
            if (k == HOLD_PHASE)
                hold_req = 1'b1;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (outcomes_due.size() != 0) begin
            $display("%0t: %0d expected results left over", $time, outcomes_due.size());
            err_count++;
        end
        $display("Run covered %0d command beats over %0d register settings and four idle patterns",
                 n_items, n_settings);
        $display("Predicted %0d dispatches and %0d wake-ups; %0d mismatches",
                 n_dispatch, n_wake, err_count);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #1000000;
        $display("Timeout at %0t", $time);
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ two_level_interrupt_controller.f @@
hw/rtl/irqc_pkg.sv
hw/rtl/irqc_cfg.sv
hw/rtl/irqc_core.sv
hw/rtl/two_level_interrupt_controller.sv
tb/tb.sv
